/* sv/kap_pkg.sv */
// shared types and constants of the keyframe animation player
`timescale 1ns / 1ps
`default_nettype none

package kap_pkg;

    localparam int SPEED_MIN  = 205;
    localparam int SPEED_ONE  = 4096;
    localparam int SPEED_MAX  = SPEED_ONE * 10;
    localparam int FRAC_BITS  = 12;
    localparam int RED_W      = 11;

    typedef enum logic [2:0] {
        KIND_KEY   = 3'd0,
        KIND_TRACK = 3'd1,
        KIND_ANIM  = 3'd2,
        KIND_PLAY  = 3'd3,
        KIND_STOP  = 3'd4,
        KIND_SPEED = 3'd5,
        KIND_TICK  = 3'd6
    } kind_t;

    localparam logic [2:0] PROP_VISIBLE = 3'd3;
    localparam logic [2:0] PROP_VOLUME  = 3'd4;
    localparam logic [2:0] PROP_PITCH   = 3'd5;

    typedef struct packed {
        logic [31:0] kt;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
    } key_t;

    typedef struct packed {
        logic [7:0] first;
        logic [8:0] count;
        logic [2:0] prop;
        logic [7:0] node;
    } trk_t;

    typedef struct packed {
        logic [7:0]  first;
        logic [8:0]  count;
        logic        loop_en;
        logic [31:0] len;
    } anm_t;

    typedef struct packed {
        logic               start;
        logic signed [63:0] dividend;
        logic signed [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quo;
        logic [31:0] rem;
    } div_rsp_t;

endpackage

`default_nettype wire

/* sv/keyframe_animation_player.sv */
// keyframe animation player: tables, players and the tick sequencer
//
// input channel (in_valid / in_stall): one beat per command. kinds write a
// key, a track or an animation, start, stop or set the speed of a player,
// or deliver a tick. in_stall is high whenever the sequencer is busy, so one
// command is in the block at a time. table writes and player commands are
// done while the sequencer stays idle.
// output channel (out_valid / out_stall): a tick sends one beat per
// non-empty track of every playing player, last_of_tick marks the final
// beat. one result is held back in a pending register so the last can be
// flagged, and an output register lets the next one be worked on while the
// receiver stalls; when both are full the sequencer waits.
// a tick walks the players in turn: a playing player advances its time,
// wraps it on a looping animation or else stops at the end; then for each
// non-empty track the keys around that time are found by a scan of the key
// memory, one read per cycle, and blended through the shared bit-serial
// divider, which the wrap uses as well.
// reset stops every player at time zero with speed 1.0; tables are not
// cleared and must be written before use.
`timescale 1ns / 1ps
`default_nettype none

module keyframe_animation_player
#(
    parameter int KEY_SLOTS       = 256,
    parameter int TRACK_SLOTS     = 64,
    parameter int ANIM_SLOTS      = 16,
    parameter int PLAYERS         = 4,
    parameter int TRACKS_PER_ANIM = 16
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [2:0]         kind,
    input  wire logic [7:0]         slot,
    input  wire logic signed [31:0] key_time,
    input  wire logic signed [31:0] value_x,
    input  wire logic signed [31:0] value_y,
    input  wire logic signed [31:0] value_z,
    input  wire logic [7:0]         start_index,
    input  wire logic [8:0]         item_count,
    input  wire logic [2:0]         property_req,
    input  wire logic [7:0]         node_id,
    input  wire logic               loop_flag,
    input  wire logic signed [31:0] amount,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              player_id,
    output logic [7:0]              target_node,
    output logic [2:0]              target_property,
    output logic signed [31:0]      out_x,
    output logic signed [31:0]      out_y,
    output logic signed [31:0]      out_z,
    output logic                    last_of_tick
);
    import kap_pkg::*;

    localparam int KW  = $clog2(KEY_SLOTS);
    localparam int TW  = (TRACK_SLOTS > 1) ? $clog2(TRACK_SLOTS) : 1;
    localparam int AW  = (ANIM_SLOTS > 1) ? $clog2(ANIM_SLOTS) : 1;
    localparam int PW  = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;
    localparam int PCW = $clog2(PLAYERS + 1);
    localparam int KCW = $clog2(TRACKS_PER_ANIM + 1);

    // sequencer states
    typedef enum logic [18:0] {
        S_IDLE   = 19'd1 << 0,
        S_PCHK   = 19'd1 << 1,
        S_PMUL   = 19'd1 << 2,
        S_PWRAP  = 19'd1 << 3,
        S_PMOD   = 19'd1 << 4,
        S_TRED   = 19'd1 << 5,
        S_TRD    = 19'd1 << 6,
        S_TGOT   = 19'd1 << 7,
        S_KRED1  = 19'd1 << 8,
        S_KA     = 19'd1 << 9,
        S_KRED2  = 19'd1 << 10,
        S_KL     = 19'd1 << 11,
        S_KSCAN  = 19'd1 << 12,
        S_BLEND  = 19'd1 << 13,
        S_BMUL   = 19'd1 << 14,
        S_BSTART = 19'd1 << 15,
        S_BDIV   = 19'd1 << 16,
        S_RES    = 19'd1 << 17,
        S_FLUSH  = 19'd1 << 18
    } state_t;

    state_t state_reg, state_next;

    // tables: key, track, animation memories with registered reads
    key_t key_mem [KEY_SLOTS];
    trk_t trk_mem [TRACK_SLOTS];
    anm_t anm_mem [ANIM_SLOTS];
    key_t key_rd_reg;
    trk_t trk_rd_reg;
    anm_t anm_rd_reg;

    logic          key_re, trk_re, anm_re;
    logic [KW-1:0] key_ra;
    logic          key_we, trk_we, anm_we;
    key_t          key_wd;
    trk_t          trk_wd;
    anm_t          anm_wd;

    // player state
    logic          play_reg  [PLAYERS];
    logic [AW-1:0] anim_reg  [PLAYERS];
    logic [31:0]   time_reg  [PLAYERS];
    logic [15:0]   speed_reg [PLAYERS];

    logic [PW-1:0] pw_idx;
    logic          pw_time_en, pw_play_en, pw_anim_en, pw_speed_en;
    logic [31:0]   pw_time_val;
    logic          pw_play_val;
    logic [15:0]   pw_speed_val;

    // sequencer registers
    logic signed [31:0] amount_reg, amount_next;
    logic [PCW-1:0] p_reg, p_next;
    logic [KCW-1:0] k_reg, k_next;
    logic [RED_W-1:0] red_reg, red_next;
    logic [TW-1:0] trk_idx_reg, trk_idx_next;
    logic [KW-1:0] ka_idx_reg, ka_idx_next;
    logic [KW-1:0] scan_idx_reg, scan_idx_next;
    logic [8:0]    i_reg, i_next;
    logic [1:0]    c_reg, c_next;
    logic [31:0]   into_reg, into_next;
    logic [31:0]   span_reg, span_next;
    key_t          a_reg, a_next;
    key_t          b_reg, b_next;
    logic [31:0]   res_x_reg, res_x_next;
    logic [31:0]   res_y_reg, res_y_next;
    logic [31:0]   res_z_reg, res_z_next;

    // pending result and output register
    logic        pend_valid_reg, pend_valid_next;
    logic [1:0]  pd_pid_reg, pd_pid_next;
    logic [7:0]  pd_node_reg, pd_node_next;
    logic [2:0]  pd_prop_reg, pd_prop_next;
    logic [31:0] pd_x_reg, pd_x_next;
    logic [31:0] pd_y_reg, pd_y_next;
    logic [31:0] pd_z_reg, pd_z_next;
    logic        out_valid_reg, out_valid_next;
    logic [1:0]  o_pid_reg, o_pid_next;
    logic [7:0]  o_node_reg, o_node_next;
    logic [2:0]  o_prop_reg, o_prop_next;
    logic [31:0] o_x_reg, o_x_next;
    logic [31:0] o_y_reg, o_y_next;
    logic [31:0] o_z_reg, o_z_next;
    logic        o_last_reg, o_last_next;

    // shared arithmetic
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    kap_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    kap_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    logic [PW-1:0] p_idx;
    logic [31:0]   cur_time;
    logic          in_fire;
    logic          out_free;
    logic [TW-1:0] trk_inc;
    logic [KW-1:0] ka_inc, scan_inc;
    logic [31:0]   va, vb;
    logic [31:0]   span_c;
    logic [31:0]   rx, ry, rz;
    logic signed [31:0] spd_clamp;

    assign p_idx    = p_reg[PW-1:0];
    assign cur_time = time_reg[p_idx];
    assign in_fire  = in_valid && (state_reg == S_IDLE);
    assign in_stall = (state_reg != S_IDLE);
    assign out_free = !out_valid_reg || !out_stall;
    assign trk_inc  = (trk_idx_reg == TW'(TRACK_SLOTS - 1)) ? '0 : trk_idx_reg + 1'b1;
    assign ka_inc   = (ka_idx_reg == KW'(KEY_SLOTS - 1)) ? '0 : ka_idx_reg + 1'b1;
    assign scan_inc = (scan_idx_reg == KW'(KEY_SLOTS - 1)) ? '0 : scan_idx_reg + 1'b1;
    assign span_c   = b_reg.kt - a_reg.kt;

    // component picked for the current blend step
    always_comb
    begin
        unique case (c_reg)
            2'd0:    begin va = a_reg.vx; vb = b_reg.vx; end
            2'd1:    begin va = a_reg.vy; vb = b_reg.vy; end
            default: begin va = a_reg.vz; vb = b_reg.vz; end
        endcase
    end

    // visible reduces to 0/1, single-component properties clear y and z
    always_comb
    begin
        rx = res_x_reg;
        ry = res_y_reg;
        rz = res_z_reg;
        if (trk_rd_reg.prop == PROP_VISIBLE)
        begin
            rx = (res_x_reg != 32'd0) ? 32'd1 : 32'd0;
        end
        if (trk_rd_reg.prop >= PROP_VISIBLE)
        begin
            ry = '0;
            rz = '0;
        end
    end

    always_comb
    begin
        if ($signed(amount) < $signed(32'(SPEED_MIN)))
            spd_clamp = 32'(SPEED_MIN);
        else if ($signed(amount) > $signed(32'(SPEED_MAX)))
            spd_clamp = 32'(SPEED_MAX);
        else
            spd_clamp = amount;
    end

    // table writes straight from the input beat
    always_comb
    begin
        key_we = in_fire && (kind == KIND_KEY) && (32'(slot) < KEY_SLOTS);
        trk_we = in_fire && (kind == KIND_TRACK) && (32'(slot) < TRACK_SLOTS);
        anm_we = in_fire && (kind == KIND_ANIM) && (32'(slot) < ANIM_SLOTS);
        key_wd = '{kt: key_time, vx: value_x, vy: value_y, vz: value_z};
        trk_wd.first = start_index;
        trk_wd.count = item_count;
        trk_wd.prop  = (property_req > PROP_PITCH) ? PROP_PITCH : property_req;
        trk_wd.node  = node_id;
        anm_wd.first = start_index;
        anm_wd.count = (32'(item_count) > TRACKS_PER_ANIM) ? 9'(TRACKS_PER_ANIM)
                                                           : item_count;
        anm_wd.loop_en = loop_flag;
        anm_wd.len     = amount;
    end

    always_ff @(posedge clk)
    begin
        if (key_we)
            key_mem[KW'(slot)] <= key_wd;
        if (key_re)
            key_rd_reg <= key_mem[key_ra];
    end

    always_ff @(posedge clk)
    begin
        if (trk_we)
            trk_mem[TW'(slot)] <= trk_wd;
        if (trk_re)
            trk_rd_reg <= trk_mem[trk_idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (anm_we)
            anm_mem[AW'(slot)] <= anm_wd;
        if (anm_re)
            anm_rd_reg <= anm_mem[anim_reg[p_idx]];
    end

    // main sequencer
    always_comb
    begin
        state_next    = state_reg;
        amount_next   = amount_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        red_next      = red_reg;
        trk_idx_next  = trk_idx_reg;
        ka_idx_next   = ka_idx_reg;
        scan_idx_next = scan_idx_reg;
        i_next        = i_reg;
        c_next        = c_reg;
        into_next     = into_reg;
        span_next     = span_reg;
        a_next        = a_reg;
        b_next        = b_reg;
        res_x_next    = res_x_reg;
        res_y_next    = res_y_reg;
        res_z_next    = res_z_reg;

        pend_valid_next = pend_valid_reg;
        pd_pid_next  = pd_pid_reg;
        pd_node_next = pd_node_reg;
        pd_prop_next = pd_prop_reg;
        pd_x_next    = pd_x_reg;
        pd_y_next    = pd_y_reg;
        pd_z_next    = pd_z_reg;

        out_valid_next = out_valid_reg && out_stall;
        o_pid_next  = o_pid_reg;
        o_node_next = o_node_reg;
        o_prop_next = o_prop_reg;
        o_x_next    = o_x_reg;
        o_y_next    = o_y_reg;
        o_z_next    = o_z_reg;
        o_last_next = o_last_reg;

        key_re = 1'b0;
        key_ra = ka_idx_reg;
        trk_re = 1'b0;
        anm_re = 1'b0;
        mul_a  = amount_reg;
        mul_b  = 32'(speed_reg[p_idx]);
        div_req.start    = 1'b0;
        div_req.dividend = 64'(signed'(cur_time));
        div_req.divisor  = anm_rd_reg.len;

        pw_idx       = p_idx;
        pw_time_en   = 1'b0;
        pw_time_val  = cur_time;
        pw_play_en   = 1'b0;
        pw_play_val  = 1'b0;
        pw_anim_en   = 1'b0;
        pw_speed_en  = 1'b0;
        pw_speed_val = spd_clamp[15:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    pw_idx = PW'(slot);
                    unique case (kind)
                        KIND_PLAY:
                        begin
                            if ((32'(slot) < PLAYERS) && (32'(start_index) < ANIM_SLOTS))
                            begin
                                pw_time_en  = 1'b1;
                                pw_time_val = '0;
                                pw_play_en  = 1'b1;
                                pw_play_val = 1'b1;
                                pw_anim_en  = 1'b1;
                            end
                        end
                        KIND_STOP:
                        begin
                            pw_play_en = (32'(slot) < PLAYERS);
                        end
                        KIND_SPEED:
                        begin
                            pw_speed_en = (32'(slot) < PLAYERS);
                        end
                        KIND_TICK:
                        begin
                            amount_next = amount;
                            p_next      = '0;
                            state_next  = S_PCHK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_PCHK:
            begin
                if (p_reg == PCW'(PLAYERS))
                    state_next = S_FLUSH;
                else if (!play_reg[p_idx])
                    p_next = p_reg + 1'b1;
                else
                begin
                    anm_re     = 1'b1;
                    state_next = S_PMUL;
                end
            end

            S_PMUL:
            begin
                // arithmetic shift of the product keeps bits 43:12
                pw_time_en  = 1'b1;
                pw_time_val = cur_time + mul_p[FRAC_BITS + 31:FRAC_BITS];
                state_next  = S_PWRAP;
            end

            S_PWRAP:
            begin
                red_next = RED_W'(anm_rd_reg.first);
                k_next   = '0;
                if ($signed(cur_time) >= $signed(anm_rd_reg.len))
                begin
                    if (anm_rd_reg.loop_en && ($signed(anm_rd_reg.len) > 0))
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_PMOD;
                    end
                    else
                    begin
                        pw_time_en  = 1'b1;
                        pw_time_val = anm_rd_reg.len;
                        pw_play_en  = 1'b1;
                        pw_play_val = 1'b0;
                        state_next  = S_TRED;
                    end
                end
                else
                    state_next = S_TRED;
            end

            S_PMOD:
            begin
                if (div_rsp.done)
                begin
                    pw_time_en  = 1'b1;
                    pw_time_val = div_rsp.rem;
                    state_next  = S_TRED;
                end
            end

            S_TRED:
            begin
                if (32'(red_reg) >= TRACK_SLOTS)
                    red_next = red_reg - RED_W'(TRACK_SLOTS);
                else
                begin
                    trk_idx_next = TW'(red_reg);
                    state_next   = S_TRD;
                end
            end

            S_TRD:
            begin
                if (9'(k_reg) == anm_rd_reg.count)
                begin
                    p_next     = p_reg + 1'b1;
                    state_next = S_PCHK;
                end
                else
                begin
                    trk_re     = 1'b1;
                    state_next = S_TGOT;
                end
            end

            S_TGOT:
            begin
                if (trk_rd_reg.count == 9'd0)
                begin
                    k_next       = k_reg + 1'b1;
                    trk_idx_next = trk_inc;
                    state_next   = S_TRD;
                end
                else
                begin
                    red_next   = RED_W'(trk_rd_reg.first);
                    state_next = S_KRED1;
                end
            end

            S_KRED1:
            begin
                if (32'(red_reg) >= KEY_SLOTS)
                    red_next = red_reg - RED_W'(KEY_SLOTS);
                else
                begin
                    ka_idx_next = KW'(red_reg);
                    key_re      = 1'b1;
                    key_ra      = KW'(red_reg);
                    state_next  = S_KA;
                end
            end

            S_KA:
            begin
                a_next = key_rd_reg;
                if ($signed(cur_time) <= $signed(key_rd_reg.kt))
                begin
                    res_x_next = key_rd_reg.vx;
                    res_y_next = key_rd_reg.vy;
                    res_z_next = key_rd_reg.vz;
                    state_next = S_RES;
                end
                else
                begin
                    red_next   = RED_W'(trk_rd_reg.first) + RED_W'(trk_rd_reg.count - 9'd1);
                    state_next = S_KRED2;
                end
            end

            S_KRED2:
            begin
                if (32'(red_reg) >= KEY_SLOTS)
                    red_next = red_reg - RED_W'(KEY_SLOTS);
                else
                begin
                    key_re     = 1'b1;
                    key_ra     = KW'(red_reg);
                    state_next = S_KL;
                end
            end

            S_KL:
            begin
                if ($signed(cur_time) >= $signed(key_rd_reg.kt))
                begin
                    a_next     = key_rd_reg;
                    res_x_next = key_rd_reg.vx;
                    res_y_next = key_rd_reg.vy;
                    res_z_next = key_rd_reg.vz;
                    state_next = S_RES;
                end
                else
                begin
                    i_next        = '0;
                    scan_idx_next = ka_inc;
                    key_re        = 1'b1;
                    key_ra        = ka_inc;
                    state_next    = S_KSCAN;
                end
            end

            S_KSCAN:
            begin
                if (((10'(i_reg) + 10'd1) < (10'(trk_rd_reg.count) - 10'd1))
                    && ($signed(key_rd_reg.kt) <= $signed(cur_time)))
                begin
                    a_next        = key_rd_reg;
                    i_next        = i_reg + 9'd1;
                    scan_idx_next = scan_inc;
                    key_re        = 1'b1;
                    key_ra        = scan_inc;
                end
                else
                begin
                    b_next     = key_rd_reg;
                    state_next = S_BLEND;
                end
            end

            S_BLEND:
            begin
                into_next = cur_time - a_reg.kt;
                span_next = span_c;
                c_next    = '0;
                if ((trk_rd_reg.prop == PROP_VISIBLE) || (span_c == 32'd0))
                begin
                    res_x_next = a_reg.vx;
                    res_y_next = a_reg.vy;
                    res_z_next = a_reg.vz;
                    state_next = S_RES;
                end
                else
                    state_next = S_BMUL;
            end

            S_BMUL:
            begin
                mul_a      = vb - va;
                mul_b      = into_reg;
                state_next = S_BSTART;
            end

            S_BSTART:
            begin
                div_req.start    = 1'b1;
                div_req.dividend = mul_p;
                div_req.divisor  = span_reg;
                state_next       = S_BDIV;
            end

            S_BDIV:
            begin
                if (div_rsp.done)
                begin
                    unique case (c_reg)
                        2'd0:    res_x_next = va + div_rsp.quo;
                        2'd1:    res_y_next = va + div_rsp.quo;
                        default: res_z_next = va + div_rsp.quo;
                    endcase
                    if (c_reg == 2'd2)
                        state_next = S_RES;
                    else
                    begin
                        c_next     = c_reg + 2'd1;
                        state_next = S_BMUL;
                    end
                end
            end

            S_RES:
            begin
                // the pending result moves out before the new one takes its place
                if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        o_pid_next  = pd_pid_reg;
                        o_node_next = pd_node_reg;
                        o_prop_next = pd_prop_reg;
                        o_x_next    = pd_x_reg;
                        o_y_next    = pd_y_reg;
                        o_z_next    = pd_z_reg;
                        o_last_next = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pd_pid_next  = 2'(p_reg);
                    pd_node_next = trk_rd_reg.node;
                    pd_prop_next = trk_rd_reg.prop;
                    pd_x_next    = rx;
                    pd_y_next    = ry;
                    pd_z_next    = rz;
                    k_next       = k_reg + 1'b1;
                    trk_idx_next = trk_inc;
                    state_next   = S_TRD;
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    o_pid_next      = pd_pid_reg;
                    o_node_next     = pd_node_reg;
                    o_prop_next     = pd_prop_reg;
                    o_x_next        = pd_x_reg;
                    o_y_next        = pd_y_reg;
                    o_z_next        = pd_z_reg;
                    o_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // player state, set by reset: stopped, time zero, speed 1.0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < PLAYERS; n++)
            begin
                play_reg[n]  <= 1'b0;
                anim_reg[n]  <= '0;
                time_reg[n]  <= '0;
                speed_reg[n] <= 16'(SPEED_ONE);
            end
        end
        else
        begin
            if (pw_time_en)
                time_reg[pw_idx] <= pw_time_val;
            if (pw_play_en)
                play_reg[pw_idx] <= pw_play_val;
            if (pw_anim_en)
                anim_reg[pw_idx] <= AW'(start_index);
            if (pw_speed_en)
                speed_reg[pw_idx] <= pw_speed_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        amount_reg   <= amount_next;
        p_reg        <= p_next;
        k_reg        <= k_next;
        red_reg      <= red_next;
        trk_idx_reg  <= trk_idx_next;
        ka_idx_reg   <= ka_idx_next;
        scan_idx_reg <= scan_idx_next;
        i_reg        <= i_next;
        c_reg        <= c_next;
        into_reg     <= into_next;
        span_reg     <= span_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        res_x_reg    <= res_x_next;
        res_y_reg    <= res_y_next;
        res_z_reg    <= res_z_next;
        pd_pid_reg   <= pd_pid_next;
        pd_node_reg  <= pd_node_next;
        pd_prop_reg  <= pd_prop_next;
        pd_x_reg     <= pd_x_next;
        pd_y_reg     <= pd_y_next;
        pd_z_reg     <= pd_z_next;
        o_pid_reg    <= o_pid_next;
        o_node_reg   <= o_node_next;
        o_prop_reg   <= o_prop_next;
        o_x_reg      <= o_x_next;
        o_y_reg      <= o_y_next;
        o_z_reg      <= o_z_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid       = out_valid_reg;
    assign player_id       = o_pid_reg;
    assign target_node     = o_node_reg;
    assign target_property = o_prop_reg;
    assign out_x           = o_x_reg;
    assign out_y           = o_y_reg;
    assign out_z           = o_z_reg;
    assign last_of_tick    = o_last_reg;
endmodule

`default_nettype wire

/* sv/kap_mul.sv */
// registered signed 32 by 32 multiplier
`timescale 1ns / 1ps
`default_nettype none

module kap_mul
(
    input  wire logic               clk,
    input  wire logic signed [31:0] a,
    input  wire logic signed [31:0] b,
    output logic signed [63:0]      p
);
    logic signed [63:0] p_reg;
    logic signed [63:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;
endmodule

`default_nettype wire

/* sv/kap_div.sv */
// bit-serial signed divider, quotient truncates toward zero
`timescale 1ns / 1ps
`default_nettype none

module kap_div
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire kap_pkg::div_req_t req,
    output kap_pkg::div_rsp_t      rsp
);
    import kap_pkg::*;

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [63:0] dn_reg, dn_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] ds_reg, ds_next;
    logic        qneg_reg, qneg_next;
    logic        rneg_reg, rneg_next;
    logic [32:0] r_sh;
    logic        ge;

    assign r_sh = {r_reg[31:0], dn_reg[63]};
    assign ge   = r_sh >= {1'b0, ds_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dn_next   = dn_reg;
        r_next    = r_reg;
        ds_next   = ds_reg;
        qneg_next = qneg_reg;
        rneg_next = rneg_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            r_next    = '0;
            dn_next   = req.dividend[63] ? 64'(-req.dividend) : 64'(req.dividend);
            ds_next   = req.divisor[31] ? 32'(-req.divisor) : 32'(req.divisor);
            qneg_next = req.dividend[63] ^ req.divisor[31];
            rneg_next = req.dividend[63];
        end
        else if (busy_reg)
        begin
            r_next   = ge ? (r_sh - {1'b0, ds_reg}) : r_sh;
            dn_next  = {dn_reg[62:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd63)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        dn_reg   <= dn_next;
        r_reg    <= r_next;
        ds_reg   <= ds_next;
        qneg_reg <= qneg_next;
        rneg_reg <= rneg_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = qneg_reg ? (32'd0 - dn_reg[31:0]) : dn_reg[31:0];
    assign rsp.rem  = rneg_reg ? (32'd0 - r_reg[31:0]) : r_reg[31:0];
endmodule

`default_nettype wire

/* sv/kap_checker.sv */
// port-level checks of the keyframe animation player and their binding
`timescale 1ns / 1ps
`default_nettype none

module kap_checker
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_stall,
    input wire logic               out_valid,
    input wire logic               out_stall,
    input wire logic [1:0]         player_id,
    input wire logic [7:0]         target_node,
    input wire logic [2:0]         target_property,
    input wire logic signed [31:0] out_x,
    input wire logic signed [31:0] out_y,
    input wire logic signed [31:0] out_z,
    input wire logic               last_of_tick
);
    import kap_pkg::*;

    // a stalled beat stays
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(out_x) && $stable(out_y) && $stable(out_z)
            && $stable(target_node) && $stable(last_of_tick))
        else $error("stalled result changed");

    // a beat that is not the last of its tick means the tick is still running
    a_mid_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_tick |-> in_stall)
        else $error("input taken in the middle of a tick");

    // visibility comes out as 0 or 1 only
    a_visible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (target_property == PROP_VISIBLE) |->
            (out_x == 32'sd0 || out_x == 32'sd1) && out_y == 32'sd0 && out_z == 32'sd0)
        else $error("visible result not reduced");

    a_prop_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> target_property <= PROP_PITCH)
        else $error("property code out of range");
endmodule

bind keyframe_animation_player kap_checker u_kap_checker (.*);

`default_nettype wire

/* dv/keyframe_animation_player_tb.sv */
// self-checking testbench for the keyframe animation player
`timescale 1ns / 1ps

module keyframe_animation_player_tb;

    import kap_pkg::*;

    // kind code the block has no use for
    localparam logic [2:0] KIND_NONE = 3'd7;
    localparam logic [2:0] PROP_POSITION = 3'd0;
    localparam logic [2:0] PROP_ROTATION = 3'd1;
    localparam logic [2:0] PROP_SCALE    = 3'd2;
    localparam logic [2:0] PROP_SPARE    = 3'd7;

    // one command beat as the driver sends it
    typedef struct {
        logic [2:0]  kind;
        logic [7:0]  slot;
        logic [31:0] kt;
        logic [31:0] vx;
        logic [31:0] vy;
        logic [31:0] vz;
        logic [7:0]  start;
        logic [8:0]  count;
        logic [2:0]  prop;
        logic [7:0]  node;
        logic        lp;
        logic [31:0] amount;
    } cmd_t;

    // one sampled-track beat
    typedef struct {
        logic [1:0]  player;
        logic [7:0]  node;
        logic [2:0]  prop;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        last;
    } sample_t;

    typedef struct {
        logic [7:0] first;
        logic [8:0] count;
        logic [2:0] prop;
        logic [7:0] node;
    } track_rec_t;

    typedef struct {
        logic [7:0]  first;
        logic [8:0]  count;
        logic        lp;
        logic [31:0] len;
    } anim_rec_t;

    typedef struct {
        logic [7:0]         anim;
        logic [31:0]        pos;
        logic signed [31:0] speed;
        logic               playing;
    } player_rec_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         kind = KIND_KEY;
    logic [7:0]         slot = '0;
    logic signed [31:0] key_time = '0;
    logic signed [31:0] value_x = '0;
    logic signed [31:0] value_y = '0;
    logic signed [31:0] value_z = '0;
    logic [7:0]         start_index = '0;
    logic [8:0]         item_count = '0;
    logic [2:0]         property_req = '0;
    logic [7:0]         node_id = '0;
    logic               loop_flag = 1'b0;
    logic signed [31:0] amount = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         player_id;
    logic [7:0]         target_node;
    logic [2:0]         target_property;
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               last_of_tick;

    keyframe_animation_player u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .kind            (kind),
        .slot            (slot),
        .key_time        (key_time),
        .value_x         (value_x),
        .value_y         (value_y),
        .value_z         (value_z),
        .start_index     (start_index),
        .item_count      (item_count),
        .property_req    (property_req),
        .node_id         (node_id),
        .loop_flag       (loop_flag),
        .amount          (amount),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .player_id       (player_id),
        .target_node     (target_node),
        .target_property (target_property),
        .out_x           (out_x),
        .out_y           (out_y),
        .out_z           (out_z),
        .last_of_tick    (last_of_tick)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow copy of the block's tables and players
    logic [31:0]  key_t_mem [256];
    logic [31:0]  key_x_mem [256];
    logic [31:0]  key_y_mem [256];
    logic [31:0]  key_z_mem [256];
    track_rec_t   tracks [64];
    anim_rec_t    anims [16];
    player_rec_t  players [4];

    // what the stimulus has written so far: only these entries get read
    bit key_ok [256];
    bit trk_ok [64];
    bit anm_ok [16];

    cmd_t    pending_cmds [$];
    sample_t expected_samples [$];
    int      errs = 0;
    bit      calm = 1'b0;

    // linear blend of one component, quotient truncated toward zero
    function automatic logic [31:0] blend_comp(logic [31:0] a, logic [31:0] b,
                                                logic [31:0] into, logic [31:0] span);
        logic signed [31:0] d32;
        logic signed [31:0] i32;
        logic signed [31:0] s32;
        logic signed [63:0] d64;
        logic signed [63:0] i64;
        logic signed [63:0] s64;
        logic signed [63:0] q;
        d32 = b - a;
        i32 = into;
        s32 = span;
        d64 = 64'(d32);
        i64 = 64'(i32);
        s64 = 64'(s32);
        q = (s64 == 0) ? 64'sd0 : (d64 * i64) / s64;
        return a + q[31:0];
    endfunction

    // value of one track at a player position
    function automatic void sample_track(track_rec_t tr, logic [31:0] pos,
                                         output logic [31:0] ox, output logic [31:0] oy,
                                         output logic [31:0] oz);
        logic [7:0]  ka;
        logic [7:0]  kb;
        logic [7:0]  kl;
        logic [8:0]  last;
        logic [31:0] into;
        logic [31:0] span;
        int          i;
        last = tr.count - 9'd1;
        ka = tr.first;
        kl = 8'(tr.first + last);
        i = 0;
        if ($signed(pos) <= $signed(key_t_mem[ka])) begin
            kb = ka;
        end
        else if ($signed(pos) >= $signed(key_t_mem[kl])) begin
            ka = kl;
            kb = kl;
        end
        else begin
            while (i + 1 < int'(last)
                   && $signed(key_t_mem[8'(tr.first + i + 1)]) <= $signed(pos))
                i++;
            ka = 8'(tr.first + i);
            kb = 8'(tr.first + i + 1);
        end
        if (ka == kb || tr.prop == PROP_VISIBLE) begin
            ox = key_x_mem[ka];
            oy = key_y_mem[ka];
            oz = key_z_mem[ka];
        end
        else begin
            into = pos - key_t_mem[ka];
            span = key_t_mem[kb] - key_t_mem[ka];
            ox = blend_comp(key_x_mem[ka], key_x_mem[kb], into, span);
            oy = blend_comp(key_y_mem[ka], key_y_mem[kb], into, span);
            oz = blend_comp(key_z_mem[ka], key_z_mem[kb], into, span);
        end
        if (tr.prop == PROP_VISIBLE) begin
            ox = (ox != 0) ? 32'd1 : 32'd0;
            oy = '0;
            oz = '0;
        end
        else if (tr.prop >= PROP_VOLUME) begin
            oy = '0;
            oz = '0;
        end
    endfunction

    // update the shadow state for one accepted command and queue its samples
    function automatic void animate_cmd(cmd_t c);
        logic signed [63:0] prod;
        logic signed [63:0] spd;
        logic signed [63:0] amt;
        logic signed [63:0] adv;
        logic signed [31:0] len;
        anim_rec_t          an;
        track_rec_t         tr;
        sample_t            s;
        int                 n;
        n = 0;
        case (c.kind)
            KIND_KEY:
            begin
                key_t_mem[c.slot] = c.kt;
                key_x_mem[c.slot] = c.vx;
                key_y_mem[c.slot] = c.vy;
                key_z_mem[c.slot] = c.vz;
            end
            KIND_TRACK:
                if (c.slot < 64) begin
                    tracks[6'(c.slot)].first = c.start;
                    tracks[6'(c.slot)].count = c.count;
                    tracks[6'(c.slot)].prop = (c.prop > PROP_PITCH) ? PROP_PITCH : c.prop;
                    tracks[6'(c.slot)].node = c.node;
                end
            KIND_ANIM:
                if (c.slot < 16) begin
                    anims[4'(c.slot)].first = c.start;
                    anims[4'(c.slot)].count = (c.count > 16) ? 9'd16 : c.count;
                    anims[4'(c.slot)].lp = c.lp;
                    anims[4'(c.slot)].len = c.amount;
                end
            KIND_PLAY:
                if (c.slot < 4 && c.start < 16) begin
                    players[2'(c.slot)].anim = c.start;
                    players[2'(c.slot)].pos = '0;
                    players[2'(c.slot)].playing = 1'b1;
                end
            KIND_STOP:
                if (c.slot < 4)
                    players[2'(c.slot)].playing = 1'b0;
            KIND_SPEED:
                if (c.slot < 4) begin
                    if ($signed(c.amount) < SPEED_MIN)
                        players[2'(c.slot)].speed = SPEED_MIN;
                    else if ($signed(c.amount) > SPEED_MAX)
                        players[2'(c.slot)].speed = SPEED_MAX;
                    else
                        players[2'(c.slot)].speed = c.amount;
                end
            KIND_TICK:
            begin
                for (int p = 0; p < 4; p++) begin
                    if (!players[p].playing)
                        continue;
                    an = anims[players[p].anim[3:0]];
                    amt = 64'($signed(c.amount));
                    spd = 64'(players[p].speed);
                    prod = amt * spd;
                    adv = prod >>> FRAC_BITS;
                    players[p].pos = players[p].pos + adv[31:0];
                    len = an.len;
                    if ($signed(players[p].pos) >= len) begin
                        if (an.lp && len > 0) begin
                            players[p].pos = $signed(players[p].pos) % len;
                        end
                        else begin
                            players[p].pos = an.len;
                            players[p].playing = 1'b0;
                        end
                    end
                    for (int k = 0; k < int'(an.count); k++) begin
                        tr = tracks[6'(an.first + k)];
                        if (tr.count == 0 || n >= 64)
                            continue;
                        sample_track(tr, players[p].pos, s.x, s.y, s.z);
                        s.player = 2'(p);
                        s.node = tr.node;
                        s.prop = tr.prop;
                        s.last = 1'b0;
                        expected_samples.push_back(s);
                        n++;
                    end
                end
                // the final beat of a tick carries the flag
                if (n > 0)
                    expected_samples[expected_samples.size() - 1].last = 1'b1;
            end
            default:
            begin
            end
        endcase
    endfunction

    // random idle gap before the next beat, drawn only outside a calm stretch
    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 14));
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // every field random, kind given
    function automatic cmd_t noise_cmd(logic [2:0] k);
        cmd_t c;
        c.kind = k;
        c.slot = 8'($urandom);
        c.kt = $urandom;
        c.vx = $urandom;
        c.vy = $urandom;
        c.vz = $urandom;
        c.start = 8'($urandom);
        c.count = 9'($urandom_range(0, 256));
        c.prop = 3'($urandom);
        c.node = 8'($urandom);
        c.lp = 1'($urandom);
        c.amount = $urandom;
        return c;
    endfunction

    task automatic push_key(logic [7:0] s, logic [31:0] t);
        cmd_t c;
        c = noise_cmd(KIND_KEY);
        c.slot = s;
        c.kt = t;
        c.vx = pick_value();
        c.vy = pick_value();
        c.vz = pick_value();
        pending_cmds.push_back(c);
        key_ok[s] = 1'b1;
    endtask

    // keys with rising times (equal times now and then), a key already written kept at random, then the track
    task automatic build_track(logic [7:0] s, logic [7:0] first, int cnt, logic [2:0] pr);
        cmd_t        c;
        logic [31:0] t;
        int          step;
        t = $urandom_range(0, 4096);
        step = ($urandom_range(0, 5) == 0) ? 0 : int'($urandom_range(1, 12288));
        for (int j = 0; j < cnt; j++) begin
            if (!key_ok[8'(first + j)] || $urandom_range(0, 1))
                push_key(8'(first + j), t);
            t = t + step;
        end
        c = noise_cmd(KIND_TRACK);
        c.slot = s;
        c.start = first;
        c.count = 9'(cnt);
        c.prop = pr;
        pending_cmds.push_back(c);
        trk_ok[s[5:0]] = 1'b1;
    endtask

    task automatic build_anim(logic [7:0] s, logic [7:0] first, int cnt, logic lp,
                              logic [31:0] len);
        cmd_t c;
        int   used;
        used = (cnt > 16) ? 16 : cnt;
        for (int k = 0; k < used; k++)
            if (!trk_ok[6'(first + k)])
                build_track(8'(6'(first + k)), 8'($urandom), $urandom_range(1, 3),
                            3'($urandom_range(0, 7)));
        c = noise_cmd(KIND_ANIM);
        c.slot = s;
        c.start = first;
        c.count = 9'(cnt);
        c.lp = lp;
        c.amount = len;
        pending_cmds.push_back(c);
        anm_ok[s[3:0]] = 1'b1;
    endtask

    task automatic push_player(logic [2:0] k, logic [7:0] s, logic [7:0] a, logic [31:0] v);
        cmd_t c;
        c = noise_cmd(k);
        c.slot = s;
        c.start = a;
        c.amount = v;
        pending_cmds.push_back(c);
    endtask

    task automatic play_random();
        logic [3:0] a;
        a = 4'($urandom);
        while (!anm_ok[a])
            a = 4'($urandom);
        push_player(KIND_PLAY, 8'($urandom_range(0, 3)), 8'(a), $urandom);
    endtask

    // driver: one command beat at a time, held while stalled
    cmd_t cur;
    int   in_gap = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end
        else begin
            if (in_valid && !in_stall) begin
                animate_cmd(cur);
                in_gap = draw_gap();
            end
            if (!in_valid || !in_stall) begin
                if (in_gap == 0 && pending_cmds.size() > 0) begin
                    cur = pending_cmds.pop_front();
                    kind <= cur.kind;
                    slot <= cur.slot;
                    key_time <= cur.kt;
                    value_x <= cur.vx;
                    value_y <= cur.vy;
                    value_z <= cur.vz;
                    start_index <= cur.start;
                    item_count <= cur.count;
                    property_req <= cur.prop;
                    node_id <= cur.node;
                    loop_flag <= cur.lp;
                    amount <= cur.amount;
                    in_valid <= 1'b1;
                end
                else begin
                    in_valid <= 1'b0;
                    if (in_gap > 0)
                        in_gap--;
                end
            end
        end
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errs++;
        end
    endtask

    // monitor: compares each result beat with the oldest expected sample
    int      out_wait = 0;
    sample_t want;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_samples.size() == 0) begin
                    $error("result beat with nothing expected");
                    errs++;
                end
                else begin
                    want = expected_samples.pop_front();
                    check_field("player_id", 32'(want.player), 32'(player_id));
                    check_field("target_node", 32'(want.node), 32'(target_node));
                    check_field("target_property", 32'(want.prop), 32'(target_property));
                    check_field("out_x", want.x, out_x);
                    check_field("out_y", want.y, out_y);
                    check_field("out_z", want.z, out_z);
                    check_field("last_of_tick", 32'(want.last), 32'(last_of_tick));
                end
                out_wait = draw_gap();
            end
            if (out_wait > 0) begin
                out_wait--;
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // stretches with and without idling
    initial
    begin
        forever begin
            repeat ($urandom_range(200, 3000)) @(negedge clk);
            calm = ~calm;
        end
    end

    // hard limit on the whole run
    initial
    begin
        #60ms;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int r;
        for (int p = 0; p < 4; p++) begin
            players[p].anim = '0;
            players[p].pos = '0;
            players[p].speed = SPEED_ONE;
            players[p].playing = 1'b0;
        end

        // directed: every property, empty track, key and track wrap,
        // track count clamp, speed clamps, ignored commands
        build_track(8'd0, 8'd0, 3, PROP_POSITION);
        build_track(8'd1, 8'd4, 2, PROP_VISIBLE);
        build_track(8'd2, 8'd8, 2, PROP_VOLUME);
        build_track(8'd3, 8'd10, 1, PROP_SPARE);
        build_track(8'd4, 8'd0, 0, PROP_ROTATION);
        build_track(8'd63, 8'd254, 4, PROP_SCALE);
        build_anim(8'd0, 8'd0, 5, 1'b1, 32'd20480);
        build_anim(8'd15, 8'd62, 3, 1'b0, 32'd8192);
        build_anim(8'd1, 8'd0, 256, 1'b1, 32'd0);
        push_player(KIND_PLAY, 8'd0, 8'd0, '0);
        push_player(KIND_PLAY, 8'd3, 8'd15, '0);
        push_player(KIND_PLAY, 8'd1, 8'd1, '0);
        push_player(KIND_SPEED, 8'd0, '0, 32'h7fff_ffff);
        push_player(KIND_SPEED, 8'd3, '0, 32'h8000_0000);
        push_player(KIND_TICK, '0, '0, 32'd4096);
        push_player(KIND_TICK, '0, '0, 32'h7fff_ffff);
        push_player(KIND_TICK, '0, '0, 32'h8000_0000);
        push_player(KIND_SPEED, 8'd200, '0, 32'd100);
        push_player(KIND_PLAY, 8'd2, 8'd200, '0);
        push_player(KIND_STOP, 8'd255, '0, '0);
        push_player(KIND_STOP, 8'd0, '0, '0);
        pending_cmds.push_back(noise_cmd(KIND_NONE));
        push_player(KIND_TICK, '0, '0, 32'd0);

        // random: mostly well-formed traffic, some noise
        while (pending_cmds.size() < 140) begin
            r = $urandom_range(0, 99);
            if (r < 25)
                push_player(KIND_TICK, '0, '0,
                            $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 12288));
            else if (r < 37)
                play_random();
            else if (r < 44)
                push_player(KIND_STOP, 8'($urandom_range(0, 3)), '0, '0);
            else if (r < 52)
                push_player(KIND_SPEED, 8'($urandom_range(0, 3)), '0,
                            $urandom_range(0, 1) ? pick_value() : $urandom_range(0, 45000));
            else if (r < 62)
                build_track(8'($urandom_range(0, 63)), 8'($urandom), $urandom_range(0, 5),
                            3'($urandom_range(0, 7)));
            else if (r < 70)
                build_anim(8'($urandom_range(0, 15)), 8'($urandom), $urandom_range(0, 6),
                           1'($urandom),
                           $urandom_range(0, 9) == 0 ? pick_value()
                                                     : $urandom_range(1, 40000));
            else if (r < 76)
                push_key(8'($urandom), $urandom);
            else begin
                // ignored: unknown kind or slots past the tables
                case ($urandom_range(0, 4))
                    0: pending_cmds.push_back(noise_cmd(KIND_NONE));
                    1: push_player(KIND_PLAY, 8'($urandom_range(4, 255)), 8'($urandom), '0);
                    2: push_player(KIND_PLAY, 8'($urandom_range(0, 3)),
                                   8'($urandom_range(16, 255)), '0);
                    3: push_player(KIND_SPEED, 8'($urandom_range(4, 255)), '0, $urandom);
                    default:
                    begin
                        cmd_t c;
                        c = noise_cmd($urandom_range(0, 1) ? KIND_TRACK : KIND_ANIM);
                        c.slot = 8'($urandom_range(64, 255));
                        pending_cmds.push_back(c);
                    end
                endcase
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        wait (pending_cmds.size() == 0);
        @(posedge clk);
        while (in_valid)
            @(posedge clk);
        wait (expected_samples.size() == 0);
        // a tick that samples nothing may still be walking its tracks
        repeat (2000) @(posedge clk);
        if (errs == 0 && expected_samples.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
